// File: hw/rtl/wcs_pkg.sv
// Shared types and constants for the waveform capture statistics block.
// Used by wcs_div, wcs_datapath, wcs_ctrl and the top level. No dependencies.
`default_nettype none

package wcs_pkg;

    localparam int MAX_SAMPLES = 8192;

    localparam int RAW_W   = 12;
    localparam int LEVEL_W = 13;
    localparam int SUM_W   = 26;
    localparam int SQ_W    = 38;
    localparam int TERM_W  = 26;   // one squared difference, at most 6144^2
    localparam int TIME_W  = 14;
    localparam int CNT_W   = 13;
    localparam int POS_W   = 13;
    localparam int IDX_W   = 14;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_STEPS  = TIME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic signed [LEVEL_W-1:0] V_BIAS        = 13'sd2048;
    localparam logic signed [LEVEL_W-1:0] MAX_INIT      = -13'sd4095;
    localparam logic signed [LEVEL_W-1:0] MIN_INIT      = 13'sd4095;
    localparam logic [SQ_W-1:0]           SQ_MAX        = {SQ_W{1'b1}};
    localparam logic [TIME_W-1:0]         TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]          CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0]          IDX_LAST      = IDX_W'(MAX_SAMPLES - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_OFS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG_LEN  = 2'd3;

    typedef enum logic [1:0] {
        LVL_LOW     = 2'd0,
        LVL_HIGH    = 2'd1,
        LVL_UNKNOWN = 2'd2
    } level_t;

    typedef struct packed {
        logic accept;      // sample beat taken this cycle
        logic div_start;   // launch both average divisions
        logic load_out;    // move totals into the output register and clear
    } cmd_t;

    typedef struct packed {
        logic capture_end; // current sample closes the capture
        logic div_done;    // averages are ready
    } status_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [IDX_W-1:0]          sample_count;
        logic [POS_W-1:0]          first_fall_pos;
        logic [POS_W-1:0]          first_rise_pos;
        logic [CNT_W-1:0]          fall_count;
        logic [CNT_W-1:0]          rise_count;
        logic [TIME_W-1:0]         low_time_avg;
        logic [TIME_W-1:0]         high_time_avg;
        logic [SQ_W-1:0]           square_sum;
        logic signed [SUM_W-1:0]   level_sum;
        logic signed [LEVEL_W-1:0] min_level;
        logic signed [LEVEL_W-1:0] max_level;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/waveform_capture_statistics.sv
// Waveform capture statistics, top level.
// Depends on wcs_pkg, wcs_ctrl, wcs_datapath (which holds wcs_div).
//
// Usage:
//   s_axis carries one raw ADC sample per beat in tdata; tlast marks the
//   final sample of a capture. A capture also ends on its MAX_SAMPLES-th beat.
//   While a capture runs, a sample is taken every cycle (s_axis_tready high).
//   After the closing beat, s_axis_tready drops while the block launches
//   the two shared-width restoring dividers (one quotient bit per cycle)
//   for the average high and low times and then loads the result register.
//   The result beat appears on m_axis once the result register is loaded.
//   The result register lets the next capture run while a result waits;
//   if the receiver still stalls when the next capture's averages are done,
//   the block holds with s_axis_tready low until m_axis_tready.
//   cfg_we writes register cfg_index (0 thresh_high, 1 thresh_low,
//   2 square_offset, 3 pretrigger_len) from cfg_data; write only when idle.
//   Reset clears all capture state, the registers to zero, and m_axis_tvalid.
`default_nettype none

module waveform_capture_statistics (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [15:0]                        s_axis_tdata,  // [11:0] sample_raw
    input  wire logic                               s_axis_tlast,  // last_sample
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // fields from bit 0: max_level, min_level, level_sum, square_sum, high_time_avg,
    // low_time_avg, rise_count, fall_count, first_rise_pos, first_fall_pos, sample_count
    output logic [$bits(wcs_pkg::result_t)-1:0]     m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [wcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wcs_pkg::CFG_W-1:0]          cfg_data
);

    wcs_pkg::cmd_t    cmd;
    wcs_pkg::status_t status;
    wcs_pkg::result_t result;

    wcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    wcs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_raw  (s_axis_tdata[wcs_pkg::RAW_W-1:0]),
        .last_sample (s_axis_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (result)
    );

    assign m_axis_tdata = result;

    // closing beat must launch the dividers on the next cycle
    a_div_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.capture_end |=> cmd.div_start && !s_axis_tready)
        else $error("divider not launched after capture end");

    // result register only overwritten when free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten while stalled");

    // no samples taken and no result loaded while the dividers are launched
    a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !cmd.accept && !cmd.load_out)
        else $error("sample accepted during division");

endmodule

`default_nettype wire

// File: hw/rtl/wcs_div.sv
// Restoring divider, one quotient bit per cycle, for the average times.
// Depends on wcs_pkg. A zero divisor gives a zero quotient.
`default_nettype none

module wcs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wcs_pkg::TIME_W-1:0]    dividend,
    input  wire logic [wcs_pkg::CNT_W-1:0]     divisor,
    output logic      [wcs_pkg::TIME_W-1:0]    quotient,
    output logic                               done
);

    logic [wcs_pkg::TIME_W-1:0]    rem_reg, rem_next;
    logic [wcs_pkg::TIME_W-1:0]    quo_reg, quo_next;
    logic [wcs_pkg::CNT_W-1:0]     dsr_reg;
    logic [wcs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          zero_reg;
    logic [wcs_pkg::TIME_W-1:0]    trial;

    // remainder stays below the divisor, so its top bit is always clear
    assign trial = {rem_reg[wcs_pkg::TIME_W-2:0], quo_reg[wcs_pkg::TIME_W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[wcs_pkg::TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[wcs_pkg::TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == wcs_pkg::DIV_CNT_W'(wcs_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
    end

    assign quotient = zero_reg ? '0 : quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wcs_datapath.sv
// Datapath: configuration registers, per-sample accumulators, hysteresis
// edge tracking, the two average dividers and the result register. Uses wcs_pkg, wcs_div.
`default_nettype none

module wcs_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wcs_pkg::cmd_t                   cmd,
    output wcs_pkg::status_t                     status,
    input  wire logic [wcs_pkg::RAW_W-1:0]       sample_raw,
    input  wire logic                            last_sample,
    input  wire logic                            cfg_we,
    input  wire logic [wcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wcs_pkg::CFG_W-1:0]       cfg_data,
    output wcs_pkg::result_t                     result
);

    logic signed [wcs_pkg::LEVEL_W-1:0] thresh_high_reg, thresh_low_reg, square_ofs_reg;
    logic [wcs_pkg::POS_W-1:0]          pretrig_reg;

    logic signed [wcs_pkg::LEVEL_W-1:0] max_reg, max_next;
    logic signed [wcs_pkg::LEVEL_W-1:0] min_reg, min_next;
    logic [wcs_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [wcs_pkg::SQ_W-1:0]           sq_sum_reg, sq_sum_next;
    logic [wcs_pkg::TERM_W-1:0]         term_reg;
    logic                               term_vld_reg;
    wcs_pkg::level_t                    level_reg, level_next;
    logic [wcs_pkg::TIME_W-1:0]         gap_reg, gap_next, gap_inc;
    logic [wcs_pkg::TIME_W-1:0]         low_tot_reg, low_tot_next;
    logic [wcs_pkg::TIME_W-1:0]         high_tot_reg, high_tot_next;
    logic [wcs_pkg::CNT_W-1:0]          rises_reg, rises_next;
    logic [wcs_pkg::CNT_W-1:0]          falls_reg, falls_next;
    logic [wcs_pkg::POS_W-1:0]          rise_pos_reg, rise_pos_next;
    logic [wcs_pkg::POS_W-1:0]          fall_pos_reg, fall_pos_next;
    logic [wcs_pkg::IDX_W-1:0]          idx_reg;

    logic signed [wcs_pkg::LEVEL_W-1:0] v;
    logic signed [wcs_pkg::LEVEL_W:0]   diff;
    logic signed [2*wcs_pkg::LEVEL_W+1:0] prod;
    logic [wcs_pkg::SQ_W:0]             sq_wide;
    logic [wcs_pkg::TIME_W:0]           low_wide, high_wide;
    logic [wcs_pkg::POS_W-1:0]          pos;
    logic [wcs_pkg::TIME_W-1:0]         high_avg, low_avg;
    logic                               high_done, low_done;

    assign v    = wcs_pkg::V_BIAS - $signed({1'b0, sample_raw});
    assign diff = $signed({v[wcs_pkg::LEVEL_W-1], v})
                - $signed({square_ofs_reg[wcs_pkg::LEVEL_W-1], square_ofs_reg});
    assign prod = diff * diff;
    assign pos  = idx_reg[wcs_pkg::POS_W-1:0];

    assign status.capture_end = last_sample || (idx_reg == wcs_pkg::IDX_LAST);
    assign status.div_done    = high_done && low_done;

    // pending squared term is registered and folded into the sum in the cycle after its sample
    assign sq_wide     = {1'b0, sq_sum_reg} + {{(wcs_pkg::SQ_W-wcs_pkg::TERM_W+1){1'b0}}, term_reg};
    assign sq_sum_next = term_vld_reg ? (sq_wide[wcs_pkg::SQ_W] ? wcs_pkg::SQ_MAX
                                                                : sq_wide[wcs_pkg::SQ_W-1:0])
                                      : sq_sum_reg;

    always_comb
    begin
        max_next      = (v > max_reg) ? v : max_reg;
        min_next      = (v < min_reg) ? v : min_reg;
        sum_next      = sum_reg + {{(wcs_pkg::SUM_W-wcs_pkg::LEVEL_W){v[wcs_pkg::LEVEL_W-1]}}, v};
        gap_inc       = gap_reg;
        if (level_reg != wcs_pkg::LVL_UNKNOWN && gap_reg != wcs_pkg::TIME_MAX)
            gap_inc = gap_reg + 1'b1;
        gap_next      = gap_inc;
        level_next    = level_reg;
        low_tot_next  = low_tot_reg;
        high_tot_next = high_tot_reg;
        rises_next    = rises_reg;
        falls_next    = falls_reg;
        rise_pos_next = rise_pos_reg;
        fall_pos_next = fall_pos_reg;
        low_wide      = {1'b0, low_tot_reg} + {1'b0, gap_inc};
        high_wide     = {1'b0, high_tot_reg} + {1'b0, gap_inc};
        priority if (v > thresh_high_reg)
        begin
            if (level_reg == wcs_pkg::LVL_LOW)
            begin
                low_tot_next = low_wide[wcs_pkg::TIME_W] ? wcs_pkg::TIME_MAX
                                                         : low_wide[wcs_pkg::TIME_W-1:0];
                gap_next = '0;
                if (rises_reg != wcs_pkg::CNT_MAX)
                    rises_next = rises_reg + 1'b1;
                if (rise_pos_reg < pretrig_reg)
                    rise_pos_next = pos;
            end
            level_next = wcs_pkg::LVL_HIGH;
        end
        else if (v < thresh_low_reg)
        begin
            if (level_reg == wcs_pkg::LVL_HIGH)
            begin
                high_tot_next = high_wide[wcs_pkg::TIME_W] ? wcs_pkg::TIME_MAX
                                                           : high_wide[wcs_pkg::TIME_W-1:0];
                gap_next = '0;
                if (falls_reg != wcs_pkg::CNT_MAX)
                    falls_next = falls_reg + 1'b1;
                if (fall_pos_reg < pretrig_reg)
                    fall_pos_next = pos;
            end
            level_next = wcs_pkg::LVL_LOW;
        end
        else
        begin
            // between the thresholds the level holds
            level_next = level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_high_reg <= '0;
            thresh_low_reg  <= '0;
            square_ofs_reg  <= '0;
            pretrig_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wcs_pkg::CFG_THRESH_HIGH: thresh_high_reg <= cfg_data;
                wcs_pkg::CFG_THRESH_LOW:  thresh_low_reg  <= cfg_data;
                wcs_pkg::CFG_SQUARE_OFS:  square_ofs_reg  <= cfg_data;
                wcs_pkg::CFG_PRETRIG_LEN: pretrig_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg      <= wcs_pkg::MAX_INIT;
            min_reg      <= wcs_pkg::MIN_INIT;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            term_vld_reg <= 1'b0;
            level_reg    <= wcs_pkg::LVL_UNKNOWN;
            gap_reg      <= '0;
            low_tot_reg  <= '0;
            high_tot_reg <= '0;
            rises_reg    <= '0;
            falls_reg    <= '0;
            rise_pos_reg <= '0;
            fall_pos_reg <= '0;
            idx_reg      <= '0;
        end
        else if (cmd.load_out)
        begin
            max_reg      <= wcs_pkg::MAX_INIT;
            min_reg      <= wcs_pkg::MIN_INIT;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            term_vld_reg <= 1'b0;
            level_reg    <= wcs_pkg::LVL_UNKNOWN;
            gap_reg      <= '0;
            low_tot_reg  <= '0;
            high_tot_reg <= '0;
            rises_reg    <= '0;
            falls_reg    <= '0;
            rise_pos_reg <= '0;
            fall_pos_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            sq_sum_reg   <= sq_sum_next;
            term_vld_reg <= cmd.accept;
            if (cmd.accept)
            begin
                max_reg      <= max_next;
                min_reg      <= min_next;
                sum_reg      <= sum_next;
                level_reg    <= level_next;
                gap_reg      <= gap_next;
                low_tot_reg  <= low_tot_next;
                high_tot_reg <= high_tot_next;
                rises_reg    <= rises_next;
                falls_reg    <= falls_next;
                rise_pos_reg <= rise_pos_next;
                fall_pos_reg <= fall_pos_next;
                // index holds at the end so the count can be read out
                if (!status.capture_end)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            term_reg <= prod[wcs_pkg::TERM_W-1:0];
    end

    wcs_div u_high_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (high_tot_reg),
        .divisor  (falls_reg),
        .quotient (high_avg),
        .done     (high_done)
    );

    wcs_div u_low_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (low_tot_reg),
        .divisor  (rises_reg),
        .quotient (low_avg),
        .done     (low_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result.max_level      <= max_reg;
            result.min_level      <= min_reg;
            result.level_sum      <= sum_reg;
            result.square_sum     <= sq_sum_reg;
            result.high_time_avg  <= high_avg;
            result.low_time_avg   <= low_avg;
            result.rise_count     <= rises_reg;
            result.fall_count     <= falls_reg;
            result.first_rise_pos <= rise_pos_reg;
            result.first_fall_pos <= fall_pos_reg;
            result.sample_count   <= idx_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wcs_ctrl.sv
// Controller: sequences sample intake, the end-of-capture divisions and
// the result handoff. Uses wcs_pkg; talks to wcs_datapath through cmd/status.
`default_nettype none

module wcs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire wcs_pkg::status_t   status,
    output wcs_pkg::cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_START,
        ST_DIV
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free      = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == ST_RUN);
    assign out_valid     = out_valid_reg;
    assign cmd.accept    = in_valid && in_ready;
    assign cmd.div_start = (state_reg == ST_START);
    assign cmd.load_out  = (state_reg == ST_DIV) && status.div_done && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_RUN:
                begin
                    if (cmd.accept && status.capture_end)
                        state_reg <= ST_START;
                end
                ST_START:
                    state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (cmd.load_out)
                        state_reg <= ST_RUN;
                end
                default:
                    state_reg <= ST_RUN;
            endcase
        end
    end

endmodule

`default_nettype wire
